@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the linked queue manager modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ASSERT_RUN(label, prop, msg)
`define ASSERT_ALL(label, prop, msg)

`endif

`endif

@@ hw/rtl/lqm_pkg.sv @@
// Types and codes shared by the linked queue manager modules.
package lqm_pkg;

   // Operation codes carried in the request opcode field.
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_QUEUED     = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_NOT_MEMBER = 2'd3
   } status_type;

   // Request payload.
   typedef struct packed {
      logic [1:0] opcode;
      logic [1:0] queue_id;
      logic [5:0] elem_id;
   } req_item_type;

   // Result payload.
   typedef struct packed {
      logic [1:0] status;
      logic       head_valid;
      logic [5:0] head_elem;
      logic [6:0] count;
   } rsp_item_type;

   // Class that the front end assigns to each request.
   typedef enum logic [2:0] {
      K_QUERY,
      K_APPEND,
      K_REMOVE,
      K_BAD_QUEUE,
      K_BAD_ELEM
   } kind_type;

   // One classified job as it sits in the front end queue.
   typedef struct packed {
      kind_type     kind;
      req_item_type item;
   } job_type;

   // Job offered from the front end to the back end.
   typedef struct packed {
      logic    valid;
      job_type job;
   } cmd_type;

   // Status returned from the back end to the front end.
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_APPEND_LINK,
      S_APPEND_FIN,
      S_REMOVE_LINK
   } state_type;

endpackage

@@ hw/rtl/linked_queue_manager.sv @@
// Top level of the linked queue manager: circular doubly linked queues over a slot pool.
//
// Requests come in on start with req_item (opcode, queue_id, elem_id) and are
// taken at a clock edge where start is high and busy is low. Each request gives
// exactly one result on rsp_item, shown for a single cycle with rsp_strobe high;
// the receiver cannot hold it off, so it must take every strobed result.
// A two-entry queue sits between the request side and the table sequencer, so
// busy rises only when that queue is full or while tables are being cleared.
// Each link memory has one write port, so the sequencer works in steps: a query,
// a refused append or remove, or an append into an empty queue ends in the read
// state, a remove adds an unlink state and an append behind an existing tail adds
// a link state and a final linking state; every result is registered.
// After reset the element flags and queue words are cleared one entry a cycle until
// every entry of both tables is written; busy stays high during that pass. All
// queues are empty afterwards and the link contents do not matter.
module linked_queue_manager #(
   parameter int QUEUES   = 4,
   parameter int ELEMENTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lqm_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output lqm_pkg::rsp_item_type rsp_item
);

   lqm_pkg::cmd_type         cmd;
   lqm_pkg::back_status_type back_status;

   // Request classification and job queue.
   lqm_front #(.QUEUES(QUEUES), .ELEMENTS(ELEMENTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .cmd        (cmd),
      .back_status(back_status)
   );

   // Table sequencer and result register.
   lqm_back #(.QUEUES(QUEUES), .ELEMENTS(ELEMENTS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .back_status(back_status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

@@ hw/rtl/lqm_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module lqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/lqm_front.sv @@
// Front end: takes requests, classifies them and queues them for the back end.
`include "assert_macros.svh"

module lqm_front #(
   parameter int QUEUES   = 4,
   parameter int ELEMENTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  lqm_pkg::req_item_type    req_item,
   output lqm_pkg::cmd_type         cmd,
   input  lqm_pkg::back_status_type back_status
);

   localparam logic [1:0] FIFO_FULL = 2'd2;

   lqm_pkg::job_type fifo_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push;
   lqm_pkg::job_type job;

   // Sort the request into the class that the back end acts on.
   always_comb begin
      job.item = req_item;
      if (32'(req_item.queue_id) >= QUEUES) begin
         job.kind = lqm_pkg::K_BAD_QUEUE;
      end else begin
         case (req_item.opcode)
            lqm_pkg::OP_APPEND: begin
               job.kind = (32'(req_item.elem_id) >= ELEMENTS) ?
                          lqm_pkg::K_BAD_ELEM : lqm_pkg::K_APPEND;
            end
            lqm_pkg::OP_REMOVE: begin
               job.kind = (32'(req_item.elem_id) >= ELEMENTS) ?
                          lqm_pkg::K_BAD_ELEM : lqm_pkg::K_REMOVE;
            end
            lqm_pkg::OP_QUERY: begin
               job.kind = lqm_pkg::K_QUERY;
            end
            default: begin
               // The unused opcode behaves as a query.
               job.kind = lqm_pkg::K_QUERY;
            end
         endcase
      end
   end

   // The queue stops new transfers while full or while the back end clears its tables.
   assign busy = (fill_ff == FIFO_FULL) || back_status.clearing;
   assign push = start && !busy;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = back_status.pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, back_status.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= job;
      end
   end

   assign cmd.valid = (fill_ff != 2'd0);
   assign cmd.job   = fifo_ff[rd_ptr_ff];

   // The fill count never reaches three.
   `ASSERT_ALL(a_fill_range, fill_ff[1] |-> !fill_ff[0], "front queue fill count out of range")
   `ASSERT_RUN(a_no_pop_empty, back_status.pop |-> fill_ff != 2'd0, "pop from empty front queue")
   `ASSERT_RUN(a_push_lands, push |=> fill_ff != 2'd0, "pushed job missing from front queue")

endmodule

@@ hw/rtl/lqm_back.sv @@
// Back end: sequences each job over the link, element and queue tables.
`include "assert_macros.svh"

module lqm_back #(
   parameter int QUEUES   = 4,
   parameter int ELEMENTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lqm_pkg::cmd_type         cmd,
   output lqm_pkg::back_status_type back_status,
   output logic                     rsp_strobe,
   output lqm_pkg::rsp_item_type    rsp_item
);

   localparam int EW        = $clog2(ELEMENTS);
   localparam int QW        = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam int CW        = $clog2(ELEMENTS + 1);
   localparam int ERW       = 1 + QW;
   localparam int QRW       = 1 + EW + CW;
   localparam int CLR_DEPTH = (ELEMENTS > QUEUES) ? ELEMENTS : QUEUES;
   localparam int CLRW      = $clog2(CLR_DEPTH);
   localparam logic [CLRW-1:0] CLR_LAST = CLRW'(CLR_DEPTH - 1);

   lqm_pkg::state_type    state_ff, state_in;
   logic [CLRW-1:0]       clr_ff, clr_in;
   lqm_pkg::job_type      job_ff, job_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   lqm_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                  pop;

   // Memory ports.
   logic          fwd_we, fwd_re, back_we, back_re, elem_we, elem_re, queue_we, queue_re;
   logic [EW-1:0] fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
   logic [EW-1:0] back_waddr, back_wdata, back_raddr, back_rdata;
   logic [EW-1:0] elem_waddr, elem_raddr;
   logic [ERW-1:0] elem_wdata, elem_rdata;
   logic [QW-1:0]  queue_waddr, queue_raddr;
   logic [QRW-1:0] queue_wdata, queue_rdata;

   // Fields of the job and of the table words.
   logic [QW-1:0] job_q;
   logic [EW-1:0] job_e;
   logic          q_present;
   logic [EW-1:0] q_head;
   logic [CW-1:0] q_count;
   logic [CW-1:0] q_count_dec;
   logic          e_queued;
   logic [QW-1:0] e_owner;

   lqm_ram #(.WIDTH(EW), .DEPTH(ELEMENTS)) u_fwd_ram (
      .clock  (clock),
      .wr_en  (fwd_we),
      .wr_addr(fwd_waddr),
      .wr_data(fwd_wdata),
      .rd_en  (fwd_re),
      .rd_addr(fwd_raddr),
      .rd_data(fwd_rdata)
   );

   lqm_ram #(.WIDTH(EW), .DEPTH(ELEMENTS)) u_back_ram (
      .clock  (clock),
      .wr_en  (back_we),
      .wr_addr(back_waddr),
      .wr_data(back_wdata),
      .rd_en  (back_re),
      .rd_addr(back_raddr),
      .rd_data(back_rdata)
   );

   lqm_ram #(.WIDTH(ERW), .DEPTH(ELEMENTS)) u_elem_ram (
      .clock  (clock),
      .wr_en  (elem_we),
      .wr_addr(elem_waddr),
      .wr_data(elem_wdata),
      .rd_en  (elem_re),
      .rd_addr(elem_raddr),
      .rd_data(elem_rdata)
   );

   lqm_ram #(.WIDTH(QRW), .DEPTH(QUEUES)) u_queue_ram (
      .clock  (clock),
      .wr_en  (queue_we),
      .wr_addr(queue_waddr),
      .wr_data(queue_wdata),
      .rd_en  (queue_re),
      .rd_addr(queue_raddr),
      .rd_data(queue_rdata)
   );

   // Build one result from a status and a view of the queue.
   function automatic lqm_pkg::rsp_item_type make_rsp(
      input logic [1:0]    st,
      input logic          present,
      input logic [EW-1:0] head,
      input logic [CW-1:0] cnt
   );
      lqm_pkg::rsp_item_type r;
      r.status     = st;
      r.head_valid = present;
      r.head_elem  = present ? 6'(head) : 6'd0;
      r.count      = 7'(cnt);
      return r;
   endfunction

   assign job_q       = QW'(job_ff.item.queue_id);
   assign job_e       = EW'(job_ff.item.elem_id);
   assign q_present   = queue_rdata[QRW-1];
   assign q_head      = queue_rdata[CW +: EW];
   assign q_count     = queue_rdata[CW-1:0];
   assign q_count_dec = (q_count != '0) ? q_count - CW'(1) : '0;
   assign e_queued    = elem_rdata[QW];
   assign e_owner     = elem_rdata[QW-1:0];

   // Sequencer: next state, table accesses and the result.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      job_in        = job_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      pop           = 1'b0;
      fwd_we        = 1'b0;
      fwd_waddr     = '0;
      fwd_wdata     = '0;
      fwd_re        = 1'b0;
      fwd_raddr     = '0;
      back_we       = 1'b0;
      back_waddr    = '0;
      back_wdata    = '0;
      back_re       = 1'b0;
      back_raddr    = '0;
      elem_we       = 1'b0;
      elem_waddr    = '0;
      elem_wdata    = '0;
      elem_re       = 1'b0;
      elem_raddr    = '0;
      queue_we      = 1'b0;
      queue_waddr   = '0;
      queue_wdata   = '0;
      queue_re      = 1'b0;
      queue_raddr   = '0;

      case (state_ff)
         lqm_pkg::S_CLEAR: begin
            // Clear the queued flags and the queue words one entry a cycle.
            elem_we     = (32'(clr_ff) < ELEMENTS);
            elem_waddr  = EW'(clr_ff);
            queue_we    = (32'(clr_ff) < QUEUES);
            queue_waddr = QW'(clr_ff);
            if (clr_ff == CLR_LAST) begin
               state_in = lqm_pkg::S_IDLE;
            end else begin
               clr_in = clr_ff + CLRW'(1);
            end
         end

         lqm_pkg::S_IDLE: begin
            // Take the next job and read its queue and element words.
            if (cmd.valid) begin
               pop         = 1'b1;
               job_in      = cmd.job;
               queue_re    = 1'b1;
               queue_raddr = QW'(cmd.job.item.queue_id);
               elem_re     = 1'b1;
               elem_raddr  = EW'(cmd.job.item.elem_id);
               state_in    = lqm_pkg::S_READ;
            end
         end

         lqm_pkg::S_READ: begin
            state_in      = lqm_pkg::S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in        = make_rsp(lqm_pkg::ST_OK, q_present, q_head, q_count);
            case (job_ff.kind)
               lqm_pkg::K_BAD_QUEUE: begin
                  rsp_in = make_rsp(lqm_pkg::ST_EMPTY, 1'b0, '0, '0);
               end
               lqm_pkg::K_BAD_ELEM: begin
                  rsp_in = make_rsp(lqm_pkg::ST_NOT_MEMBER, q_present, q_head, q_count);
               end
               lqm_pkg::K_APPEND: begin
                  if (e_queued) begin
                     rsp_in = make_rsp(lqm_pkg::ST_QUEUED, q_present, q_head, q_count);
                  end else if (!q_present) begin
                     // The element becomes the sole member, linked to itself.
                     fwd_we      = 1'b1;
                     fwd_waddr   = job_e;
                     fwd_wdata   = job_e;
                     back_we     = 1'b1;
                     back_waddr  = job_e;
                     back_wdata  = job_e;
                     elem_we     = 1'b1;
                     elem_waddr  = job_e;
                     elem_wdata  = {1'b1, job_q};
                     queue_we    = 1'b1;
                     queue_waddr = job_q;
                     queue_wdata = {1'b1, job_e, q_count + CW'(1)};
                     rsp_in      = make_rsp(lqm_pkg::ST_OK, 1'b1, job_e, q_count + CW'(1));
                  end else begin
                     // Fetch the tail, which is the head's backward link.
                     rsp_strobe_in = 1'b0;
                     back_re       = 1'b1;
                     back_raddr    = q_head;
                     state_in      = lqm_pkg::S_APPEND_LINK;
                  end
               end
               lqm_pkg::K_REMOVE: begin
                  if (!q_present) begin
                     rsp_in = make_rsp(lqm_pkg::ST_EMPTY, q_present, q_head, q_count);
                  end else if (!e_queued || (e_owner != job_q)) begin
                     rsp_in = make_rsp(lqm_pkg::ST_NOT_MEMBER, q_present, q_head, q_count);
                  end else begin
                     // Fetch both neighbors of the element.
                     rsp_strobe_in = 1'b0;
                     fwd_re        = 1'b1;
                     fwd_raddr     = job_e;
                     back_re       = 1'b1;
                     back_raddr    = job_e;
                     state_in      = lqm_pkg::S_REMOVE_LINK;
                  end
               end
               default: begin
                  // A query reports the queue as it stands.
               end
            endcase
         end

         lqm_pkg::S_APPEND_LINK: begin
            // Point the head back and the tail forward at the new element.
            back_we    = 1'b1;
            back_waddr = q_head;
            back_wdata = job_e;
            fwd_we     = 1'b1;
            fwd_waddr  = back_rdata;
            fwd_wdata  = job_e;
            state_in   = lqm_pkg::S_APPEND_FIN;
         end

         lqm_pkg::S_APPEND_FIN: begin
            // Link the new element between tail and head and count it.
            back_we       = 1'b1;
            back_waddr    = job_e;
            back_wdata    = back_rdata;
            fwd_we        = 1'b1;
            fwd_waddr     = job_e;
            fwd_wdata     = q_head;
            elem_we       = 1'b1;
            elem_waddr    = job_e;
            elem_wdata    = {1'b1, job_q};
            queue_we      = 1'b1;
            queue_waddr   = job_q;
            queue_wdata   = {1'b1, q_head, q_count + CW'(1)};
            rsp_in        = make_rsp(lqm_pkg::ST_OK, 1'b1, q_head, q_count + CW'(1));
            rsp_strobe_in = 1'b1;
            state_in      = lqm_pkg::S_IDLE;
         end

         lqm_pkg::S_REMOVE_LINK: begin
            // Unlink the element; the queue empties when it linked to itself.
            elem_we       = 1'b1;
            elem_waddr    = job_e;
            elem_wdata    = {1'b0, e_owner};
            queue_we      = 1'b1;
            queue_waddr   = job_q;
            rsp_strobe_in = 1'b1;
            state_in      = lqm_pkg::S_IDLE;
            if (fwd_rdata == job_e) begin
               queue_wdata = {1'b0, {EW{1'b0}}, q_count_dec};
               rsp_in      = make_rsp(lqm_pkg::ST_OK, 1'b0, '0, q_count_dec);
            end else begin
               back_we     = 1'b1;
               back_waddr  = fwd_rdata;
               back_wdata  = back_rdata;
               fwd_we      = 1'b1;
               fwd_waddr   = back_rdata;
               fwd_wdata   = fwd_rdata;
               queue_wdata = {1'b1, (q_head == job_e) ? fwd_rdata : q_head, q_count_dec};
               rsp_in      = make_rsp(lqm_pkg::ST_OK, 1'b1,
                                      (q_head == job_e) ? fwd_rdata : q_head, q_count_dec);
            end
         end

         default: begin
            state_in = lqm_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lqm_pkg::S_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign back_status.pop      = pop;
   assign back_status.clearing = (state_ff == lqm_pkg::S_CLEAR);
   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_item             = rsp_ff;

   `ASSERT_RUN(a_rsp_ends_job, rsp_strobe_ff |-> state_ff == lqm_pkg::S_IDLE, "result shown while a job is still in progress")
   `ASSERT_RUN(a_rsp_spacing, rsp_strobe_ff |=> !rsp_strobe_ff, "two results in consecutive cycles")
   `ASSERT_RUN(a_clear_once, state_ff != lqm_pkg::S_CLEAR |=> state_ff != lqm_pkg::S_CLEAR, "clearing pass re-entered after it finished")

endmodule
